/* rtl/core/mdz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_pkg: shared types and constants of the zigzag reorder core
// Configuration codes, controller states and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mdz_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int TOT_W     = 2 * CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_SHOW
  } mdz_state_t;

  typedef struct packed {
    logic load;   // store the accepted word, advance or clear the load count
    logic rd;     // read the element at the current scan position
    logic step;   // advance the scan, or rewind it after the last word
  } mdz_cmd_t;

  typedef struct packed {
    logic load_done;  // the word being loaded completes the matrix
    logic scan_last;  // the scan position is the final cell
  } mdz_status_t;

endpackage
`default_nettype wire

/* rtl/core/mdz_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_datapath: element store, load counter and zigzag scan walker
// Holds the dimension registers, writes words row-major into the store and
// reads them back along the diagonal zigzag path on command.
// ----------------------------------------------------------------------------
module mdz_datapath import mdz_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_wr_en,
  input  wire        [CFG_IDX_W-1:0] cfg_index,
  input  wire        [CFG_W-1:0]     cfg_wdata,
  input  wire signed [DATA_W-1:0]    in_data,
  input  wire mdz_cmd_t              cmd,
  output mdz_status_t                status,
  output logic signed [DATA_W-1:0]   rd_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CFG_W-1:0]  row_count_r, col_count_r;
  logic [CFG_W-1:0]  rows, cols;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  load_cnt_r, emit_cnt_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              up_r, up_nxt;
  logic [CFG_W-1:0]  row_p1, col_p1;
  logic [ADDR_W-1:0] scan_addr;
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_DIM_RESET;
      col_count_r <= CFG_DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        REG_COL_COUNT: col_count_r <= cfg_wdata;
      endcase
    end
  end

  // Saturate dimensions into 1..MAX
  always_comb begin
    if (row_count_r == '0)                   rows = CFG_W'(1);
    else if (row_count_r > CFG_W'(MAX_ROWS)) rows = CFG_W'(MAX_ROWS);
    else                                     rows = row_count_r;
    if (col_count_r == '0)                   cols = CFG_W'(1);
    else if (col_count_r > CFG_W'(MAX_COLS)) cols = CFG_W'(MAX_COLS);
    else                                     cols = col_count_r;
    total = TOT_W'(rows) * TOT_W'(cols);
  end

  assign status.load_done = (TOT_W'(load_cnt_r) + TOT_W'(1)) >= total;
  assign status.scan_last = (TOT_W'(emit_cnt_r) + TOT_W'(1)) == total;

  // Load counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else if (cmd.load) begin
      load_cnt_r <= status.load_done ? '0 : load_cnt_r + CNT_W'(1);
    end
  end

  // Zigzag walk: reverse at each edge
  always_comb begin
    row_p1  = CFG_W'(row_r) + CFG_W'(1);
    col_p1  = CFG_W'(col_r) + CFG_W'(1);
    row_nxt = row_r;
    col_nxt = col_r;
    up_nxt  = up_r;
    if (up_r) begin
      if (row_r == '0 || col_p1 >= cols) begin
        if (col_p1 < cols) col_nxt = col_r + COL_W'(1);
        else               row_nxt = row_r + ROW_W'(1);
        up_nxt = 1'b0;
      end else begin
        row_nxt = row_r - ROW_W'(1);
        col_nxt = col_r + COL_W'(1);
      end
    end else begin
      if (col_r == '0 || row_p1 >= rows) begin
        if (row_p1 < rows) row_nxt = row_r + ROW_W'(1);
        else               col_nxt = col_r + COL_W'(1);
        up_nxt = 1'b1;
      end else begin
        row_nxt = row_r + ROW_W'(1);
        col_nxt = col_r - COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      up_r       <= 1'b1;
      emit_cnt_r <= '0;
    end else if (cmd.step) begin
      if (status.scan_last) begin
        row_r      <= '0;
        col_r      <= '0;
        up_r       <= 1'b1;
        emit_cnt_r <= '0;
      end else begin
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        up_r       <= up_nxt;
        emit_cnt_r <= emit_cnt_r + CNT_W'(1);
      end
    end
  end

  assign scan_addr = ADDR_W'(TOT_W'(row_r) * TOT_W'(cols) + TOT_W'(col_r));

  // Element store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[load_cnt_r[ADDR_W-1:0]] <= in_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[scan_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/core/mdz_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_ctrl: sequencer of the zigzag reorder core
// Loads words until the matrix is full, then reads and presents each
// element of the scan in turn, holding it until the receiver takes it.
// ----------------------------------------------------------------------------
module mdz_ctrl import mdz_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire              out_tready,
  input  wire mdz_status_t status,
  output mdz_cmd_t         cmd
);

  mdz_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (status.load_done) state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.step  = 1'b1;
          state_nxt = status.scan_last ? ST_LOAD : ST_READ;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/matrix_diagonal_zigzag_reorder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_reorder_core: diagonal zigzag scan of a matrix
// Usage: write row_count (index 0) and col_count (index 1) through the cfg
// port while idle; values of zero act as one, values above the maximum
// saturate. Stream the matrix in row-major order on the in_ channel, one
// word per element. After the final element the block emits every element
// on the out_ channel in zigzag order (start top-left, move up-right first,
// reverse at each edge); out_tlast marks the final word of the scan.
// Sequence: in_tready is high throughout the load phase. Once the last
// element is accepted the core reads the first scan element from the
// store, then presents it; each later result likewise needs a store read
// before its presentation, and no read starts while a result is shown.
// in_tready is low for the whole output phase.
// Stall: a result holds on out_tdata/out_tlast until out_tready is seen.
// Reset: clears the load count and scan position and sets both dimensions
// to 8; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module matrix_diagonal_zigzag_reorder_core import mdz_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // Configuration write port
  input  wire                        cfg_wr_en,
  input  wire        [CFG_IDX_W-1:0] cfg_index,
  input  wire        [CFG_W-1:0]     cfg_wdata,
  // Input stream
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire signed [DATA_W-1:0]    in_tdata,   // [31:0] element_value
  // Result stream
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic signed [DATA_W-1:0]   out_tdata,  // [31:0] out_value
  output logic                       out_tlast   // out_last
);

  mdz_cmd_t    cmd;
  mdz_status_t status;

  // Sequencer: load phase, then read/present per scan word
  mdz_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Store, counters and zigzag walker
  mdz_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .rd_data   (out_tdata)
  );

  // Last flag follows the scan position held during presentation
  assign out_tlast = status.scan_last;

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the diagonal zigzag reorder core
// Streams row-major matrices into the core under several dimension settings
// and checks every output word, in order, against a local zigzag scan of the
// same data. A short directed table comes first, then random frames under
// three sender/receiver idling profiles, one with a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import mdz_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYC   = 8;
  localparam int HOLD_CYC     = 400;
  localparam int PHASE_WORDS  = 90;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } zz_word_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    value;
    logic                 typed;
    logic [DATA_W-1:0]    want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata = '0;   // [31:0] element_value
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;       // [31:0] out_value
  logic                 out_tlast;

  // Shadow state of the core: stored elements, load count, dimensions
  logic [DATA_W-1:0] elem_store [0:STORE_DEPTH-1];
  int                load_cnt;
  logic [CFG_W-1:0]  row_reg;
  logic [CFG_W-1:0]  col_reg;

  zz_word_t  scan_words [$];   // words emitted by the latest accepted element
  zz_word_t  pending_scan [$]; // words still owed by the core, oldest first
  plan_row_t plan [$];

  int mismatches = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  matrix_diagonal_zigzag_reorder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Hard stop in case the core hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYC;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each accepted output word with the oldest owed word
  always @(posedge clk) begin
    zz_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scan.size() == 0) begin
        $error("out_value: no word expected, got %h", out_tdata);
        mismatches++;
      end else begin
        w = pending_scan.pop_front();
        if (out_tdata !== w.value) begin
          $error("out_value: expected %h, got %h", w.value, out_tdata);
          mismatches++;
        end
        if (out_tlast !== w.last) begin
          $error("out_last: expected %b, got %b", w.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  function automatic int dim_in_use(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  // Store one element; on completing the matrix, build the full zigzag scan
  task automatic store_element(input logic [DATA_W-1:0] v);
    int rows, cols, total, r, c, k;
    logic up;
    zz_word_t w;
    scan_words.delete();
    rows  = dim_in_use(row_reg);
    cols  = dim_in_use(col_reg);
    total = rows * cols;
    if (load_cnt < STORE_DEPTH) begin
      elem_store[load_cnt] = v;
      load_cnt++;
    end
    if (load_cnt >= total) begin
      r  = 0;
      c  = 0;
      up = 1'b1;
      for (k = 0; k < total; k++) begin
        w.value = elem_store[r * cols + c];
        w.last  = (k == total - 1);
        scan_words = {scan_words, w};
        if (up) begin
          // at the top or right edge: turn, stepping right or else down
          if (r == 0 || c + 1 >= cols) begin
            if (c + 1 < cols) c++;
            else r++;
            up = 1'b0;
          end else begin
            r--;
            c++;
          end
        end else begin
          // at the left or bottom edge: turn, stepping down or else right
          if (c == 0 || r + 1 >= rows) begin
            if (r + 1 < rows) r++;
            else c++;
            up = 1'b1;
          end else begin
            r++;
            c--;
          end
        end
        r = r & 7;
        c = c & 7;
      end
      load_cnt = 0;
    end
  endtask

  // Offer one word; called and returning at a falling edge
  task automatic push_word(input logic [DATA_W-1:0] v, input logic typed,
                           input logic [DATA_W-1:0] want);
    zz_word_t w;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    store_element(v);
    if (typed) begin
      // hand-written expectation for a 1x1 frame
      w.value = want;
      w.last  = 1'b1;
      pending_scan = {pending_scan, w};
    end else begin
      pending_scan = {pending_scan, scan_words};
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed word, then let the core go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_scan.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Write one register; returns at a falling edge after the write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_ROW_COUNT) row_reg = val;
    else col_reg = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic plan_row_t mk_row(input plan_kind_t kind,
                                      input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] value,
                                      input logic typed);
    plan_row_t p;
    p.kind  = kind;
    p.idx   = idx;
    p.value = value;
    p.typed = typed;
    p.want  = value;
    return p;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input plan_kind_t kind,
                                  input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value,
                                  input logic typed);
    plan = {plan, mk_row(kind, idx, value, typed)};
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;                        // acts as one
      1:       return CFG_W'($urandom_range(9, 15)); // saturates to eight
      2:       return CFG_DIM_RESET;
      default: return CFG_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase, frame_no, phase_words, total;

    load_cnt = 0;
    row_reg  = CFG_DIM_RESET;
    col_reg  = CFG_DIM_RESET;

    // Directed table. 1x1 frames (zero written to both dimensions) echo
    // their word straight back, so those rows carry a typed expectation.
    add_row(ROW_CFG, REG_ROW_COUNT, 32'd0, 1'b0);
    add_row(ROW_CFG, REG_COL_COUNT, 32'd0, 1'b0);
    add_row(ROW_WORD, '0, 32'h7FFF_FFFF, 1'b1);
    add_row(ROW_WORD, '0, 32'h8000_0000, 1'b1);
    add_row(ROW_WORD, '0, 32'h0000_0000, 1'b1);
    add_row(ROW_WORD, '0, 32'hFFFF_FFFF, 1'b1);
    // 15 rows saturate to eight: a single column scanned top to bottom
    add_row(ROW_CFG, REG_ROW_COUNT, 32'd15, 1'b0);
    add_row(ROW_CFG, REG_COL_COUNT, 32'd1, 1'b0);
    for (int i = 0; i < 8; i++)
      add_row(ROW_WORD, '0, 32'h1000_0000 + i, 1'b0);
    add_row(ROW_CFG, REG_ROW_COUNT, 32'd2, 1'b0);
    add_row(ROW_CFG, REG_COL_COUNT, 32'd3, 1'b0);
    for (int i = 0; i < 6; i++)
      add_row(ROW_WORD, '0, 32'hA5A5_0000 + i, 1'b0);
    // Shrink the matrix mid-load: the next word finds the count already
    // past rows*cols and flushes a 1x4 scan of the first four words.
    add_row(ROW_CFG, REG_ROW_COUNT, 32'd8, 1'b0);
    add_row(ROW_CFG, REG_COL_COUNT, 32'd8, 1'b0);
    for (int i = 0; i < 5; i++)
      add_row(ROW_WORD, '0, 32'h5A5A_0000 + i, 1'b0);
    add_row(ROW_CFG, REG_ROW_COUNT, 32'd1, 1'b0);
    add_row(ROW_CFG, REG_COL_COUNT, 32'd4, 1'b0);
    add_row(ROW_WORD, '0, 32'hC3C3_C3C3, 1'b0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 21;
    rx_idle_pct = 80;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].value[CFG_W-1:0]);
      end else begin
        push_word(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    // Random frames under three idling profiles
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 21; rx_idle_pct = 80; end
        1: begin tx_idle_pct = 80; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      frame_no = 0;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        // Keep the dimensions for the second frame of the last phase so the
        // sender keeps offering words while the receiver is held off.
        if (frame_no == 0 || (!(phase == 2 && frame_no == 1) &&
                              $urandom_range(0, 1))) begin
          settle();
          write_reg(REG_ROW_COUNT, pick_dim());
          write_reg(REG_COL_COUNT, pick_dim());
        end
        if (phase == 2 && frame_no == 0) hold_request = 1'b1;
        total = dim_in_use(row_reg) * dim_in_use(col_reg);
        for (int i = 0; i < total; i++) push_word(pick_value(), 1'b0, '0);
        phase_words += total;
        frame_no++;
      end
    end

    settle();
    repeat (2 * SETTLE_CYC) @(negedge clk);
    if (mismatches == 0 && pending_scan.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mdz_pkg.sv
rtl/core/mdz_datapath.sv
rtl/core/mdz_ctrl.sv
rtl/core/matrix_diagonal_zigzag_reorder_core.sv
dv/testbench.sv
